### rtl/rhd_pkg.sv
// Shared constants and the result record type of the record header deframer.
`timescale 1ns / 1ps

package rhd_pkg;

  localparam int unsigned HdrLen         = 16;
  localparam int unsigned StoreDepth     = HdrLen - 1;
  localparam int unsigned CountBits      = 4;
  localparam int unsigned SkipBits       = 33;
  localparam int unsigned OutOffsetBits  = 48;
  localparam int unsigned OffsetBitsDef  = 48;
  localparam logic [7:0]  TypeCountReset = 8'd5;

  typedef struct packed {
    logic                     unknown_type;
    logic [7:0]               record_type;
    logic [31:0]              period_us;
    logic [31:0]              start_time;
    logic [23:0]              meta_length;
    logic [31:0]              payload_length;
    logic [OutOffsetBits-1:0] header_offset;
  } rhd_result_t;

endpackage

### rtl/rhd_parser.sv
// Header parser: collects header bytes, decodes the record and counts body bytes to skip.
`timescale 1ns / 1ps

module rhd_parser
  import rhd_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  input  logic [7:0]  type_count_i,
  output logic        res_valid_o,
  output rhd_result_t res_o
);

  localparam logic [CountBits-1:0] LastStoreIdx = CountBits'(StoreDepth);

  logic [7:0]             hdr_q [StoreDepth];
  logic [7:0]             hdr_d [StoreDepth];
  logic [CountBits-1:0]   count_q, count_d;
  logic                   skipping_q, skipping_d;
  logic [SkipBits-1:0]    remain_q, remain_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] hstart_q, hstart_d;

  logic [CountBits-1:0]   cur_count;
  logic                   cur_skipping;
  logic [OFFSET_BITS-1:0] cur_pos;
  logic [SkipBits-1:0]    body_len;
  logic                   unknown;

  // A file start drops whatever record was in progress before this byte is taken.
  assign cur_count    = file_start_i ? '0 : count_q;
  assign cur_skipping = file_start_i ? 1'b0 : skipping_q;
  assign cur_pos      = file_start_i ? '0 : pos_q;

  assign unknown = hdr_q[0] >= type_count_i;

  assign res_o.unknown_type   = unknown;
  assign res_o.record_type    = hdr_q[0];
  assign res_o.period_us      = {hdr_q[1], hdr_q[2], hdr_q[3], hdr_q[4]};
  assign res_o.start_time     = {hdr_q[5], hdr_q[6], hdr_q[7], hdr_q[8]};
  assign res_o.meta_length    = {hdr_q[9], hdr_q[10], hdr_q[11]};
  assign res_o.payload_length = {hdr_q[12], hdr_q[13], hdr_q[14], data_byte_i};
  assign res_o.header_offset  = OutOffsetBits'(hstart_q);

  assign body_len = SkipBits'(res_o.meta_length) + SkipBits'(res_o.payload_length);

  always_comb begin
    hdr_d       = hdr_q;
    count_d     = cur_count;
    skipping_d  = cur_skipping;
    remain_d    = remain_q;
    hstart_d    = hstart_q;
    res_valid_o = 1'b0;
    if (cur_skipping) begin
      remain_d   = remain_q - SkipBits'(1);
      skipping_d = (remain_d != '0);
    end else if (cur_count < LastStoreIdx) begin
      if (cur_count == '0) begin
        hstart_d = cur_pos;
      end
      // The store is a shift line: after fifteen bytes entry 0 holds the type byte.
      for (int i = 0; i < StoreDepth - 1; i++) begin
        hdr_d[i] = hdr_q[i+1];
      end
      hdr_d[StoreDepth-1] = data_byte_i;
      count_d = cur_count + CountBits'(1);
    end else begin
      res_valid_o = 1'b1;
      count_d     = '0;
      if (!unknown) begin
        remain_d   = body_len;
        skipping_d = (body_len != '0);
      end
    end
    pos_d = cur_pos + OFFSET_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      skipping_q <= 1'b0;
      remain_q   <= '0;
      pos_q      <= '0;
      hstart_q   <= '0;
    end else if (step_i) begin
      count_q    <= count_d;
      skipping_q <= skipping_d;
      remain_q   <= remain_d;
      pos_q      <= pos_d;
      hstart_q   <= hstart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hdr_q <= hdr_d;
    end
  end

endmodule

### rtl/record_header_deframer.sv
// Top level of the record header deframer: input register, parser and result register.
`timescale 1ns / 1ps

// The block takes a file one byte per item on the input channel (data_byte_i,
// with file_start_i high on the first byte of each file) and delivers one
// decoded header record on the output channel when the sixteenth byte of a
// header arrives. Body bytes of a known record type are consumed silently; a
// record of unknown type skips nothing and the next byte starts a header.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The type count register is written through cfg_valid_i and
// cfg_data_i, which is always ready, and should only be written while idle.
// The result reaches the outputs once the last header byte has waited in the
// input register and the parser's record has been captured by the result
// register. Throughput is one byte per cycle unless a stalled receiver holds
// a full result register. While the receiver stalls, the result register
// holds and the input register keeps one further byte; in_stall_o rises only
// when both are full. Reset clears the parser's counters and flags (not its
// header store), the byte offset and the valid flags of both register stages,
// and sets the type count to five. A partial header at the end of a file is
// dropped at the next file start.
module record_header_deframer
  import rhd_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     file_start_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     unknown_type_o,
  output logic [7:0]               record_type_o,
  output logic [31:0]              period_us_o,
  output logic [31:0]              start_time_o,
  output logic [23:0]              meta_length_o,
  output logic [31:0]              payload_length_o,
  output logic [OutOffsetBits-1:0] header_offset_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [7:0]               cfg_data_i
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_start_q;
  logic        out_valid_q;
  rhd_result_t out_q;
  logic [7:0]  type_count_q;

  logic        out_free;
  logic        step;
  logic        res_valid;
  rhd_result_t res;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign cfg_ready_o = 1'b1;

  rhd_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .file_start_i(in_start_q),
    .type_count_i(type_count_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      type_count_q <= TypeCountReset;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= step && res_valid;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        type_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= file_start_i;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign unknown_type_o   = out_q.unknown_type;
  assign record_type_o    = out_q.record_type;
  assign period_us_o      = out_q.period_us;
  assign start_time_o     = out_q.start_time;
  assign meta_length_o    = out_q.meta_length;
  assign payload_length_o = out_q.payload_length;
  assign header_offset_o  = out_q.header_offset;

  // The input side only stalls when the result register is full and held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register could move");

  // A new result can only come from a byte that sat in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result appeared without a byte in the input register");

  // The unknown flag agrees with the type count in force.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (unknown_type_o == (record_type_o >= type_count_q)))
    else $error("unknown type flag disagrees with the type count");

endmodule

### tb/record_header_deframer_test.sv
// Self-checking testbench for the record header deframer, with its own header decoder.
`timescale 1ns / 1ps

module record_header_deframer_test;
  import rhd_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseItems  = 500;
  localparam int unsigned NumRows     = 14;

  typedef struct packed {
    logic        set_tc;
    logic [7:0]  tc;
    logic        fs;
    logic [4:0]  hdr_n;
    logic [7:0]  typ;
    logic [31:0] period;
    logic [31:0] t0;
    logic [23:0] meta;
    logic [31:0] data;
    logic [15:0] body_n;
    logic        typed;
    logic        x_unk;
    logic [47:0] x_off;
  } dir_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        file_start_i = 1'b0;
  logic        out_stall_i  = 1'b0;
  logic        cfg_valid_i  = 1'b0;
  logic [7:0]  cfg_data_i   = 8'd0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        unknown_type_o;
  logic [7:0]  record_type_o;
  logic [31:0] period_us_o;
  logic [31:0] start_time_o;
  logic [23:0] meta_length_o;
  logic [31:0] payload_length_o;
  logic [OutOffsetBits-1:0] header_offset_o;
  logic        cfg_ready_o;

  // Shadow of the deframer's state and its type count register.
  logic [7:0]               tc_shadow = TypeCountReset;
  logic [7:0]               hdr_mem [StoreDepth];
  logic [CountBits-1:0]     hdr_fill  = '0;
  logic                     body_skip = 1'b0;
  logic [SkipBits-1:0]      skip_left = '0;
  logic [OffsetBitsDef-1:0] file_pos  = '0;
  logic [OffsetBitsDef-1:0] hdr_pos   = '0;

  rhd_result_t headers_due [$];
  rhd_result_t due_rec;
  dir_row_t    dir_rows [NumRows];
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned sent_items   = 0;
  int unsigned burst_left   = 0;
  logic        restart_next = 1'b0;
  logic        hold_off_req  = 1'b0;
  logic        hold_off_done = 1'b0;

  record_header_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .file_start_i     (file_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .unknown_type_o   (unknown_type_o),
    .record_type_o    (record_type_o),
    .period_us_o      (period_us_o),
    .start_time_o     (start_time_o),
    .meta_length_o    (meta_length_o),
    .payload_length_o (payload_length_o),
    .header_offset_o  (header_offset_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("record_header_deframer: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want_v);
    if (got !== want_v) begin
      report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want_v));
    end
  endtask

  // Decodes one byte of the file; returns 1 when it completes a header.
  function automatic bit deframe_step(input logic [7:0] b, input logic fs,
                                      output rhd_result_t rec);
    bit hit;
    logic [23:0] meta;
    logic [31:0] data;
    hit = 1'b0;
    rec = '0;
    if (fs) begin
      file_pos  = '0;
      hdr_fill  = '0;
      body_skip = 1'b0;
      skip_left = '0;
    end
    if (body_skip) begin
      skip_left = skip_left - 1'b1;
      if (skip_left == '0) body_skip = 1'b0;
    end else if (hdr_fill < CountBits'(StoreDepth)) begin
      if (hdr_fill == '0) hdr_pos = file_pos;
      hdr_mem[hdr_fill] = b;
      hdr_fill = hdr_fill + 1'b1;
    end else begin
      meta = {hdr_mem[9], hdr_mem[10], hdr_mem[11]};
      data = {hdr_mem[12], hdr_mem[13], hdr_mem[14], b};
      rec.unknown_type   = (hdr_mem[0] >= tc_shadow);
      rec.record_type    = hdr_mem[0];
      rec.period_us      = {hdr_mem[1], hdr_mem[2], hdr_mem[3], hdr_mem[4]};
      rec.start_time     = {hdr_mem[5], hdr_mem[6], hdr_mem[7], hdr_mem[8]};
      rec.meta_length    = meta;
      rec.payload_length = data;
      rec.header_offset  = hdr_pos[OutOffsetBits-1:0];
      hit = 1'b1;
      hdr_fill = '0;
      if (!rec.unknown_type) begin
        skip_left = SkipBits'(meta) + SkipBits'(data);
        body_skip = (skip_left != '0);
      end
    end
    file_pos = file_pos + 1'b1;
    return hit;
  endfunction

  // Mostly back-to-back items, with short gaps and the odd long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 100);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fs, input logic use_typed,
                           input rhd_result_t typed_rec);
    rhd_result_t pred;
    int unsigned gap;
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    file_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (deframe_step(b, fs, pred)) begin
      headers_due.insert(headers_due.size(), use_typed ? typed_rec : pred);
    end
    sent_items++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_record(input logic fs, input int unsigned hdr_n, input logic [7:0] typ,
                             input logic [31:0] period, input logic [31:0] t0,
                             input logic [23:0] meta, input logic [31:0] data,
                             input int unsigned body_n, input logic typed,
                             input logic x_unk, input logic [47:0] x_off);
    logic [127:0] hdr;
    rhd_result_t want;
    hdr  = {typ, period, t0, meta, data};
    want = {x_unk, typ, period, t0, meta, data, x_off};
    for (int unsigned i = 0; i < hdr_n; i++) begin
      send_byte(hdr[127 - 8 * i -: 8], fs && (i == 0), typed && (i == HdrLen - 1), want);
    end
    for (int unsigned j = 0; j < body_n; j++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, want);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (headers_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_type_count(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tc_shadow = v;
  endtask

  // Mostly well-formed records; the rest are cut short or plain noise, after which
  // the next record starts a new file so that parsing lines up again.
  task automatic send_random_record();
    logic [7:0]  typ;
    logic [31:0] period, t0, data;
    logic [23:0] meta;
    logic        fs, known;
    int unsigned kind, hdr_n, body_n, r;
    kind = $urandom_range(0, 99);
    fs = restart_next || ($urandom_range(0, 24) == 0);
    restart_next = 1'b0;
    r = $urandom_range(0, 9);
    if (r < 5 && tc_shadow != 0) typ = 8'($urandom_range(0, tc_shadow - 1));
    else if (r < 7) typ = tc_shadow;
    else typ = 8'($urandom_range(0, 255));
    known  = (typ < tc_shadow);
    period = $urandom;
    t0     = $urandom;
    meta   = 24'($urandom_range(0, 12));
    data   = $urandom_range(0, 24);
    if ($urandom_range(0, 9) == 0) begin
      meta = '0;
      data = '0;
    end else if ($urandom_range(0, 19) == 0) begin
      data = $urandom_range(100, 400);
    end
    hdr_n  = HdrLen;
    body_n = known ? int'(meta) + int'(data) : 0;
    if (kind >= 96) begin
      repeat ($urandom_range(1, 20)) begin
        send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0), 1'b0, '0);
      end
      restart_next = 1'b1;
      return;
    end else if (kind >= 90) begin
      body_n = $urandom_range(0, body_n);
      restart_next = 1'b1;
    end else if (kind >= 80) begin
      hdr_n  = $urandom_range(1, HdrLen - 1);
      body_n = 0;
      restart_next = 1'b1;
    end else if (kind >= 65) begin
      meta   = 24'($urandom);
      data   = $urandom;
      body_n = known ? $urandom_range(0, 40) : 0;
      restart_next = known;
    end
    send_record(fs, hdr_n, typ, period, t0, meta, data, body_n, 1'b0, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (headers_due.size() == 0) begin
        report_mismatch("header record delivered with none pending");
      end else begin
        due_rec = headers_due.pop_front();
        check_field("unknown_type", 64'(unknown_type_o), 64'(due_rec.unknown_type));
        check_field("record_type", 64'(record_type_o), 64'(due_rec.record_type));
        check_field("period_us", 64'(period_us_o), 64'(due_rec.period_us));
        check_field("start_time", 64'(start_time_o), 64'(due_rec.start_time));
        check_field("meta_length", 64'(meta_length_o), 64'(due_rec.meta_length));
        check_field("payload_length", 64'(payload_length_o), 64'(due_rec.payload_length));
        check_field("header_offset", 64'(header_offset_o), 64'(due_rec.header_offset));
      end
    end
  end

  // Receiver: free-running stretches, short and long stalls, and one long hold-off.
  initial begin : receiver
    int unsigned n;
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else if ($urandom_range(0, 9) < 4) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] phase_tc [4];
    int unsigned target;
    dir_row_t row;
    // set_tc, tc, fs, hdr_n, type, period, start, meta, data, body, typed, unknown, offset
    dir_rows[0]  = '{1'b0, 8'd0, 1'b0, 5'd16, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     24'hFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1'b1, 1'b1, 48'd0};
    dir_rows[1]  = '{1'b0, 8'd0, 1'b0, 5'd16, 8'h00, 32'h0, 32'h0,
                     24'h0, 32'h0, 16'd0, 1'b1, 1'b0, 48'd16};
    dir_rows[2]  = '{1'b0, 8'd0, 1'b0, 5'd16, 8'h04, 32'h1234_5678, 32'h8000_0001,
                     24'd3, 32'd5, 16'd8, 1'b1, 1'b0, 48'd32};
    dir_rows[3]  = '{1'b0, 8'd0, 1'b0, 5'd16, 8'h05, 32'h0000_0001, 32'h7FFF_FFFF,
                     24'd16, 32'd7, 16'd0, 1'b1, 1'b1, 48'd56};
    // A header cut short by the next file start yields nothing.
    dir_rows[4]  = '{1'b0, 8'd0, 1'b0, 5'd9, 8'h01, 32'hAAAA_AAAA, 32'h5555_5555,
                     24'h0, 32'h0, 16'd0, 1'b0, 1'b0, 48'd0};
    dir_rows[5]  = '{1'b0, 8'd0, 1'b1, 5'd16, 8'h02, 32'h0101_0101, 32'hFEDC_BA98,
                     24'hFF_FFFF, 32'hFFFF_FFFF, 16'd20, 1'b1, 1'b0, 48'd0};
    // File start arrives while the previous body is still being skipped.
    dir_rows[6]  = '{1'b0, 8'd0, 1'b1, 5'd16, 8'h03, 32'hC3C3_3C3C, 32'h0,
                     24'h0, 32'd1, 16'd1, 1'b1, 1'b0, 48'd0};
    dir_rows[7]  = '{1'b0, 8'd0, 1'b0, 5'd16, 8'h00, 32'hA5A5_5A5A, 32'h5A5A_A5A5,
                     24'h0, 32'h0, 16'd0, 1'b1, 1'b0, 48'd17};
    dir_rows[8]  = '{1'b1, 8'd255, 1'b0, 5'd16, 8'hFE, 32'h0F0F_F0F0, 32'hF0F0_0F0F,
                     24'd1, 32'd0, 16'd1, 1'b1, 1'b0, 48'd33};
    dir_rows[9]  = '{1'b0, 8'd0, 1'b0, 5'd16, 8'hFF, 32'h8000_0000, 32'h0000_0001,
                     24'd2, 32'd3, 16'd0, 1'b1, 1'b1, 48'd50};
    dir_rows[10] = '{1'b1, 8'd1, 1'b0, 5'd16, 8'h00, 32'h0, 32'hFFFF_0000,
                     24'd0, 32'd2, 16'd2, 1'b0, 1'b0, 48'd0};
    dir_rows[11] = '{1'b0, 8'd0, 1'b0, 5'd16, 8'h01, 32'h7F7F_7F7F, 32'h0000_FFFF,
                     24'd4, 32'd4, 16'd0, 1'b0, 1'b0, 48'd0};
    // With a type count of zero every type is unknown.
    dir_rows[12] = '{1'b1, 8'd0, 1'b1, 5'd16, 8'h00, 32'h0000_0010, 32'h0000_0020,
                     24'd1, 32'd1, 16'd0, 1'b1, 1'b1, 48'd0};
    dir_rows[13] = '{1'b0, 8'd0, 1'b0, 5'd16, 8'hFF, 32'h0, 32'h0,
                     24'd0, 32'd0, 16'd0, 1'b0, 1'b0, 48'd0};
    phase_tc[0] = 8'd1;
    phase_tc[1] = 8'd255;
    phase_tc[2] = 8'($urandom_range(2, 254));
    phase_tc[3] = TypeCountReset;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned k = 0; k < NumRows; k++) begin
      row = dir_rows[k];
      if (row.set_tc) begin
        wait_drained();
        write_type_count(row.tc);
      end
      send_record(row.fs, row.hdr_n, row.typ, row.period, row.t0, row.meta, row.data,
                  row.body_n, row.typed, row.x_unk, row.x_off);
    end

    for (int unsigned p = 0; p < 4; p++) begin
      wait_drained();
      write_type_count(phase_tc[p]);
      if (p == 1) hold_off_req = 1'b1;
      target = sent_items + PhaseItems;
      while (sent_items < target) send_random_record();
    end

    wait_drained();
    if (headers_due.size() != 0) report_mismatch("header records never delivered");
    if (mismatches == 0) begin
      $display("record_header_deframer: match");
    end else begin
      $display("record_header_deframer: mismatch");
    end
    $finish;
  end

endmodule
